// ----- rtl/core/rsbs_pkg.sv -----
// Package: record and channel payload types shared by the sort block.
`default_nettype none
package rsbs_pkg;

  localparam int MAX_RECORDS_DEF = 64;

  localparam int SCORE_W  = 10;
  localparam int ENROLL_W = 40;
  localparam int PHONE_W  = 34;

  typedef struct packed {
    logic [SCORE_W-1:0]  score;
    logic [ENROLL_W-1:0] enrollment;
    logic [PHONE_W-1:0]  phone;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef struct packed {
    logic [SCORE_W-1:0]  score;
    logic [ENROLL_W-1:0] enrollment;
    logic [PHONE_W-1:0]  phone;
    logic                final_item;
  } in_item_t;

  typedef struct packed {
    logic [SCORE_W-1:0]  out_score;
    logic [ENROLL_W-1:0] out_enrollment;
    logic [PHONE_W-1:0]  out_phone;
    logic                overflowed;
    logic                last_out;
  } out_item_t;

endpackage
`default_nettype wire

// ----- rtl/core/rsbs_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none
module rsbs_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- rtl/core/rsbs_seq.sv -----
// Sequencer: load, exchange sort over the record RAM, and result emission.
`default_nettype none
module rsbs_seq #(
  parameter int MAX_RECORDS = rsbs_pkg::MAX_RECORDS_DEF,
  localparam int AW = $clog2(MAX_RECORDS),
  localparam int CW = $clog2(MAX_RECORDS + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rsbs_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rsbs_pkg::out_item_t     out_data,
  output logic                    mem_we,
  output logic [AW-1:0]           mem_waddr,
  output rsbs_pkg::rec_t          mem_wdata,
  output logic [AW-1:0]           mem_raddr,
  input  wire rsbs_pkg::rec_t     mem_rdata
);
  import rsbs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_KLD   = 3'd1;
  localparam logic [2:0] S_LRUN  = 3'd2;
  localparam logic [2:0] S_KWR   = 3'd3;
  localparam logic [2:0] S_ERD   = 3'd4;
  localparam logic [2:0] S_EWT   = 3'd5;
  localparam logic [2:0] S_EHOLD = 3'd6;

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RECORDS);

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] l_r, l_nxt;
  logic [CW-1:0] e_r, e_nxt;
  logic          out_valid_r, out_valid_nxt;
  rec_t          cur_r, cur_nxt;
  out_item_t     out_r, out_nxt;

  logic [CW-1:0] n_load;
  logic [CW-1:0] kp1, kp2, lp1, ep1;

  assign kp1 = k_r + CW'(1);
  assign kp2 = k_r + CW'(2);
  assign lp1 = l_r + CW'(1);
  assign ep1 = e_r + CW'(1);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    k_nxt         = k_r;
    l_nxt         = l_r;
    e_nxt         = e_r;
    out_valid_nxt = out_valid_r;
    cur_nxt       = cur_r;
    out_nxt       = out_r;
    n_load        = cnt_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r[AW-1:0];
    mem_wdata     = '{score: in_data.score, enrollment: in_data.enrollment,
                      phone: in_data.phone};
    mem_raddr     = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (cnt_r < MAX_CNT) begin
            mem_we  = 1'b1;
            n_load  = cnt_r + CW'(1);
            cnt_nxt = n_load;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.final_item) begin
            k_nxt = '0;
            e_nxt = '0;
            if (n_load >= CW'(2)) begin
              state_nxt = S_KLD;
            end else begin
              state_nxt = S_ERD;
            end
          end
        end
      end
      S_KLD: begin
        cur_nxt   = mem_rdata;
        l_nxt     = kp1;
        mem_raddr = kp1[AW-1:0];
        state_nxt = S_LRUN;
      end
      S_LRUN: begin
        mem_raddr = lp1[AW-1:0];
        if (mem_rdata.score > cur_r.score) begin
          mem_we    = 1'b1;
          mem_waddr = l_r[AW-1:0];
          mem_wdata = cur_r;
          cur_nxt   = mem_rdata;
        end
        if (lp1 < cnt_r) begin
          l_nxt = lp1;
        end else begin
          state_nxt = S_KWR;
        end
      end
      S_KWR: begin
        mem_we    = 1'b1;
        mem_waddr = k_r[AW-1:0];
        mem_wdata = cur_r;
        mem_raddr = kp1[AW-1:0];
        if (kp2 < cnt_r) begin
          k_nxt     = kp1;
          state_nxt = S_KLD;
        end else begin
          e_nxt     = '0;
          state_nxt = S_ERD;
        end
      end
      S_ERD: begin
        mem_raddr = e_r[AW-1:0];
        state_nxt = S_EWT;
      end
      S_EWT: begin
        out_nxt = '{out_score: mem_rdata.score, out_enrollment: mem_rdata.enrollment,
                    out_phone: mem_rdata.phone, overflowed: ovf_r,
                    last_out: (ep1 == cnt_r)};
        out_valid_nxt = 1'b1;
        state_nxt     = S_EHOLD;
      end
      S_EHOLD: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_r.last_out) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            e_nxt     = ep1;
            mem_raddr = ep1[AW-1:0];
            state_nxt = S_EWT;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      k_r         <= '0;
      l_r         <= '0;
      e_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      k_r         <= k_nxt;
      l_r         <= l_nxt;
      e_r         <= e_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT)
    else $error("record count above capacity");

  a_no_write_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !mem_we)
    else $error("RAM write while a result is pending");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LRUN) |-> (l_r < cnt_r && k_r < l_r))
    else $error("scan index outside the loaded set");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && out_r.last_out) |=> (!in_stall && cnt_r == '0))
    else $error("block not empty after the final transfer");

endmodule
`default_nettype wire

// ----- rtl/core/record_sort_by_score_desc.sv -----
// Top level: records in, descending-score exchange sort, records out.
// Load: one record per cycle; the closing record starts the sort, or the emission if under two are held.
// Sort of n records: one compare per cycle over n(n-1)/2 pairs, plus a load step (S_KLD) and a
// write-back step (S_KWR) per outer position, set by the single read port of the record RAM.
// Emission: S_ERD reads the first record; each result is registered in S_EWT, held in S_EHOLD while out_stall holds.
// Reset (rst_n low, synchronous) empties the set and clears the overflow flag; RAM not cleared.
`default_nettype none
module record_sort_by_score_desc #(
  parameter int MAX_RECORDS = rsbs_pkg::MAX_RECORDS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rsbs_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rsbs_pkg::out_item_t     out_data
);
  import rsbs_pkg::*;

  localparam int AW = $clog2(MAX_RECORDS);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  rec_t          mem_wdata;
  rec_t          mem_rdata;

  rsbs_seq #(
    .MAX_RECORDS(MAX_RECORDS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  rsbs_ram #(
    .W    (REC_W),
    .DEPTH(MAX_RECORDS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire
